// ===== design/lcdn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, register indexes and helpers for the character display
// nibble interface sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // wait counter width and its saturation limit
    localparam int WAIT_BITS = 16;
    localparam int WAIT_MAX  = (1 << WAIT_BITS) - 1;
    // width wide enough for any unsaturated wait value and for the counter
    localparam int SAT_BITS  = (WAIT_BITS > 17) ? WAIT_BITS : 17;

    // fixed waits of the nibble reset sequence
    localparam int INIT_LONG_WAIT  = 4100;
    localparam int INIT_SHORT_WAIT = 100;

    // item commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_FUNCTION_SET    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_MODE      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DISPLAY_CONTROL = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REVERSE_PINS    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_POWER_UP_WAIT   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMMAND_WAIT    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLEAR_WAIT      = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADDRESS_WAIT    = 3'd7;

    // display instructions with special timing
    localparam logic [7:0] INSTR_CLEAR = 8'h01;

    // result group kinds held in the queue
    localparam logic [1:0] KIND_SINGLE = 2'd0;  // one result, current pins
    localparam logic [1:0] KIND_STROBE = 2'd1;  // enable high then low
    localparam logic [1:0] KIND_BYTE   = 2'd2;  // two strobes, high nibble first

    // queue depth between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] command;
        logic       register_select;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic       accepted;
        logic       busy_res;
        logic       enable_pin;
        logic       select_pin;
        logic [3:0] data_pins;
        logic       last_result;
    } t_out;

    // one queued group of results
    typedef struct packed {
        logic [1:0] kind;
        logic       acc;
        logic       busy;
        logic       sel;
        logic [3:0] nib_hi;
        logic [3:0] nib_lo;
    } t_entry;

    // clamp a wait value to what the counter holds
    function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [SAT_BITS-1:0] v);
        logic [WAIT_BITS-1:0] r;
        if (v > SAT_BITS'(WAIT_MAX)) begin
            r = '1;
        end else begin
            r = v[WAIT_BITS-1:0];
        end
        return r;
    endfunction

    // map a nibble onto the data pins
    function automatic logic [3:0] pin_nibble(input logic [3:0] n, input logic rev);
        logic [3:0] r;
        if (rev) begin
            r = {n[0], n[1], n[2], n[3]};
        end else begin
            r = n;
        end
        return r;
    endfunction

endpackage

// ===== design/lcdn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts items, holds configuration, the init sequencer, the wait counter
// and the pin levels, and classifies each item into one queued result group.
// ----------------------------------------------------------------------------
module lcdn_front
    import lcdn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_in                      i_data,
    input  logic                     i_full,
    output logic                     o_push,
    output t_entry                   o_entry,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RST1  = 9'b000000010,
        ST_RST2  = 9'b000000100,
        ST_RST3  = 9'b000001000,
        ST_NIB2  = 9'b000010000,
        ST_FSET  = 9'b000100000,
        ST_EMODE = 9'b001000000,
        ST_DCTRL = 9'b010000000,
        ST_CLEAR = 9'b100000000
    } t_init;

    // configuration
    logic [7:0]  r_function_set;
    logic [7:0]  r_entry_mode;
    logic [7:0]  r_display_control;
    logic        r_reverse;
    logic [15:0] r_power_up_wait;
    logic [7:0]  r_command_wait;
    logic [11:0] r_clear_wait;
    logic [7:0]  r_address_wait;

    // sequencer state
    t_init                r_init, n_init;
    logic [WAIT_BITS-1:0] r_wait, n_wait;
    logic                 r_sel, n_sel;
    logic [3:0]           r_dat, n_dat;

    logic                 busy;
    logic                 act;
    logic                 do_byte;
    logic                 byte_rs;
    logic [7:0]           byte_val;
    logic [SAT_BITS-1:0]  byte_wait;

    assign o_push = i_valid && !i_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function_set    <= 8'h28;
            r_entry_mode      <= 8'h06;
            r_display_control <= 8'h0C;
            r_reverse         <= 1'b1;
            r_power_up_wait   <= 16'd45000;
            r_command_wait    <= 8'd40;
            r_clear_wait      <= 12'd1640;
            r_address_wait    <= 8'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FUNCTION_SET:    r_function_set    <= i_cfg_data[7:0];
                REG_ENTRY_MODE:      r_entry_mode      <= i_cfg_data[7:0];
                REG_DISPLAY_CONTROL: r_display_control <= i_cfg_data[7:0];
                REG_REVERSE_PINS:    r_reverse         <= i_cfg_data[0];
                REG_POWER_UP_WAIT:   r_power_up_wait   <= i_cfg_data[15:0];
                REG_COMMAND_WAIT:    r_command_wait    <= i_cfg_data[7:0];
                REG_CLEAR_WAIT:      r_clear_wait      <= i_cfg_data[11:0];
                REG_ADDRESS_WAIT:    r_address_wait    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // busy wait after a byte: extra waits only for instructions
    always_comb begin
        byte_wait = SAT_BITS'(r_command_wait);
        if (!byte_rs && byte_val == INSTR_CLEAR) begin
            byte_wait = byte_wait + SAT_BITS'(r_clear_wait);
        end
        if (!byte_rs && byte_val[7]) begin
            byte_wait = byte_wait + SAT_BITS'(r_address_wait);
        end
    end

    // item classification and next state
    always_comb begin
        n_init   = r_init;
        n_wait   = r_wait;
        n_sel    = r_sel;
        n_dat    = r_dat;
        busy     = (r_init != ST_IDLE) || (r_wait != '0);
        act      = 1'b0;
        do_byte  = 1'b0;
        byte_rs  = 1'b0;
        byte_val = i_data.byte_value;
        o_entry.kind   = KIND_SINGLE;
        o_entry.acc    = 1'b1;
        o_entry.nib_hi = 4'd0;
        o_entry.nib_lo = 4'd0;

        case (i_data.command)
            CMD_TICK: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                    act    = (r_wait == WAIT_BITS'(1));
                end else begin
                    act = 1'b1;
                end
                if (act) begin
                    unique case (r_init)
                        ST_IDLE: ;
                        ST_RST1: begin
                            o_entry.kind   = KIND_STROBE;
                            o_entry.nib_hi = pin_nibble(4'h3, r_reverse);
                            n_wait = sat_wait(SAT_BITS'(INIT_LONG_WAIT));
                            n_init = ST_RST2;
                        end
                        ST_RST2: begin
                            o_entry.kind   = KIND_STROBE;
                            o_entry.nib_hi = pin_nibble(4'h3, r_reverse);
                            n_wait = sat_wait(SAT_BITS'(INIT_SHORT_WAIT));
                            n_init = ST_RST3;
                        end
                        ST_RST3: begin
                            o_entry.kind   = KIND_STROBE;
                            o_entry.nib_hi = pin_nibble(4'h3, r_reverse);
                            n_wait = sat_wait(SAT_BITS'(INIT_SHORT_WAIT));
                            n_init = ST_NIB2;
                        end
                        ST_NIB2: begin
                            o_entry.kind   = KIND_STROBE;
                            o_entry.nib_hi = pin_nibble(4'h2, r_reverse);
                            n_sel  = 1'b0;
                            n_wait = '0;
                            n_init = ST_FSET;
                        end
                        ST_FSET: begin
                            do_byte  = 1'b1;
                            byte_val = r_function_set;
                            n_init   = ST_EMODE;
                        end
                        ST_EMODE: begin
                            do_byte  = 1'b1;
                            byte_val = r_entry_mode;
                            n_init   = ST_DCTRL;
                        end
                        ST_DCTRL: begin
                            do_byte  = 1'b1;
                            byte_val = r_display_control;
                            n_init   = ST_CLEAR;
                        end
                        ST_CLEAR: begin
                            do_byte  = 1'b1;
                            byte_val = INSTR_CLEAR;
                            n_init   = ST_IDLE;
                        end
                        default: n_init = ST_IDLE;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (busy) begin
                    o_entry.acc = 1'b0;
                end else begin
                    do_byte = 1'b1;
                    byte_rs = i_data.register_select;
                end
            end
            CMD_START: begin
                if (busy) begin
                    o_entry.acc = 1'b0;
                end else begin
                    n_sel  = 1'b0;
                    n_dat  = 4'd0;
                    n_wait = sat_wait(SAT_BITS'(r_power_up_wait));
                    n_init = ST_RST1;
                end
            end
            default: o_entry.acc = 1'b0;
        endcase

        // a byte transfer: high nibble strobe then low nibble strobe
        if (do_byte) begin
            o_entry.kind   = KIND_BYTE;
            o_entry.nib_hi = pin_nibble(byte_val[7:4], r_reverse);
            o_entry.nib_lo = pin_nibble(byte_val[3:0], r_reverse);
            n_sel  = byte_rs;
            n_wait = sat_wait(byte_wait);
        end

        // pin level after the item
        if (o_entry.kind == KIND_STROBE) begin
            n_dat = o_entry.nib_hi;
        end else if (o_entry.kind == KIND_BYTE) begin
            n_dat = o_entry.nib_lo;
        end
        if (o_entry.kind == KIND_SINGLE) begin
            o_entry.nib_hi = n_dat;
        end
        o_entry.sel  = n_sel;
        o_entry.busy = (n_init != ST_IDLE) || (n_wait != '0);
    end

    // state update on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= ST_IDLE;
            r_wait <= '0;
            r_sel  <= 1'b0;
            r_dat  <= 4'd0;
        end else if (o_push) begin
            r_init <= n_init;
            r_wait <= n_wait;
            r_sel  <= n_sel;
            r_dat  <= n_dat;
        end
    end

endmodule

// ===== design/lcdn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_queue
// Short FIFO of result groups between the front and the back.
// ----------------------------------------------------------------------------
module lcdn_queue
    import lcdn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);

    t_entry                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wptr;
    logic [QUEUE_PTR_BITS-1:0] r_rptr;
    logic [QUEUE_PTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/lcdn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdn_back
// Plays out each queued group as one, two or four results, one per transfer.
// ----------------------------------------------------------------------------
module lcdn_back
    import lcdn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_empty,
    input  t_entry i_entry,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_stall,
    output t_out   o_data
);

    t_entry     r_cur;
    logic       r_have;
    logic [1:0] r_phase;
    logic [1:0] last_phase;
    logic       is_last;
    logic       done;

    // phase of the final result of the group
    always_comb begin
        case (r_cur.kind)
            KIND_STROBE: last_phase = 2'd1;
            KIND_BYTE:   last_phase = 2'd3;
            default:     last_phase = 2'd0;
        endcase
    end

    assign is_last = (r_phase == last_phase);
    assign done    = r_have && !i_stall && is_last;
    assign o_pop   = !i_empty && (!r_have || done);
    assign o_valid = r_have;

    // result fields
    always_comb begin
        o_data.accepted    = r_cur.acc;
        o_data.busy_res    = r_cur.busy;
        o_data.select_pin  = r_cur.sel;
        o_data.enable_pin  = (r_cur.kind != KIND_SINGLE) && !r_phase[0];
        o_data.data_pins   = (r_cur.kind == KIND_BYTE && r_phase[1]) ? r_cur.nib_lo
                                                                     : r_cur.nib_hi;
        o_data.last_result = is_last;
    end

    // current group and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_phase <= 2'd0;
        end else if (o_pop) begin
            r_have  <= 1'b1;
            r_phase <= 2'd0;
        end else if (done) begin
            r_have  <= 1'b0;
            r_phase <= 2'd0;
        end else if (r_have && !i_stall) begin
            r_phase <= r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_entry;
        end
    end

endmodule

// ===== design/char_lcd_nibble_interface_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_sequencer
// Character display 4-bit bus sequencer: power-up init, byte writes, waits.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_data): tick, write or start items.
// Each transfer updates the sequencer state at once and queues one group of
// results. Output channel (o_valid / i_stall / o_data): one result per
// transfer; a tick with no action or a refused item gives one result, a reset
// nibble two (enable high, low) and a byte four (high nibble, low nibble).
// Throughput: one item per cycle while the four-entry group queue has room;
// the output side moves one result per cycle while the receiver does not
// stall, so byte-sized groups drain slower than items arrive and fill the
// queue, which then stalls the input.
// When the receiver stalls, the current result holds and the queue absorbs
// up to four further items before o_stall rises.
// Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) is to be written only
// while idle by the user; the block itself does not enforce it.
// Reset (synchronous, active low) restores the default register values,
// clears the sequencer, the wait counter, the pin levels and the queue.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_sequencer
    import lcdn_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  t_in                      i_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output t_out                     o_data,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry push_entry;
    t_entry head_entry;

    assign o_stall = full;

    // front: state update and classification
    lcdn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // group queue
    lcdn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    // back: result playout
    lcdn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_entry (head_entry),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== verif/tb_char_lcd_nibble_interface_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_interface_sequencer
// Self-checking bench for the 4-bit character display sequencer. A scoreboard
// class tracks the init sequence, the busy counter and the pin levels, and
// expands every accepted tick, write or start into the pin results it should
// produce. Every returned result is compared field by field. The run covers
// directed corner items, full power-up sequences, and random traffic under
// several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------

import lcdn_pkg::*;

class lcd_pin_scoreboard;

    typedef enum logic [3:0] {
        INIT_IDLE, INIT_RESET_1, INIT_RESET_2, INIT_RESET_3, INIT_BUS_4BIT,
        INIT_FUNCTION, INIT_ENTRY, INIT_DISPLAY, INIT_CLEAR
    } init_phase_e;

    localparam logic [3:0] RESET_NIBBLE = 4'h3;
    localparam logic [3:0] BUS4_NIBBLE  = 4'h2;
    localparam int SUM_BITS    = SAT_BITS + 1;
    localparam int MAX_PRINTED = 20;

    // register copies
    logic [7:0]           function_byte;
    logic [7:0]           entry_byte;
    logic [7:0]           display_byte;
    logic                 reverse_pins;
    logic [15:0]          power_wait;
    logic [7:0]           cmd_wait;
    logic [11:0]          clr_wait;
    logic [7:0]           addr_wait;

    // sequencer state
    init_phase_e          phase;
    logic [WAIT_BITS-1:0] wait_left;
    logic                 sel_lvl;
    logic                 en_lvl;
    logic [3:0]           data_lvl;

    t_out                 group_q[$];
    t_out                 pin_results_q[$];
    int                   errors;

    function new();
        function_byte = 8'h28;
        entry_byte    = 8'h06;
        display_byte  = 8'h0C;
        reverse_pins  = 1'b1;
        power_wait    = 16'd45000;
        cmd_wait      = 8'd40;
        clr_wait      = 12'd1640;
        addr_wait     = 8'd100;
        phase         = INIT_IDLE;
        wait_left     = '0;
        sel_lvl       = 1'b0;
        en_lvl        = 1'b0;
        data_lvl      = 4'h0;
        errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] v);
        case (idx)
            REG_FUNCTION_SET:    function_byte = v[7:0];
            REG_ENTRY_MODE:      entry_byte    = v[7:0];
            REG_DISPLAY_CONTROL: display_byte  = v[7:0];
            REG_REVERSE_PINS:    reverse_pins  = v[0];
            REG_POWER_UP_WAIT:   power_wait    = v[15:0];
            REG_COMMAND_WAIT:    cmd_wait      = v[7:0];
            REG_CLEAR_WAIT:      clr_wait      = v[11:0];
            REG_ADDRESS_WAIT:    addr_wait     = v[7:0];
            default: ;
        endcase
    endfunction

    function bit is_busy();
        return (phase != INIT_IDLE) || (wait_left != '0);
    endfunction

    function int pending();
        return pin_results_q.size();
    endfunction

    function logic [WAIT_BITS-1:0] clamp_wait(logic [SUM_BITS-1:0] v);
        if (v > SUM_BITS'(WAIT_MAX)) begin
            return '1;
        end
        return v[WAIT_BITS-1:0];
    endfunction

    // snapshot of the pins as one result
    function void push_pins();
        t_out r;
        r            = '0;
        r.enable_pin = en_lvl;
        r.select_pin = sel_lvl;
        r.data_pins  = data_lvl;
        group_q.push_back(r);
    endfunction

    // enable high then low with the nibble on the pins
    function void strobe(logic [3:0] nib);
        data_lvl = reverse_pins ? {nib[0], nib[1], nib[2], nib[3]} : nib;
        en_lvl   = 1'b1;
        push_pins();
        en_lvl   = 1'b0;
        push_pins();
    endfunction

    // high nibble, low nibble, then the busy time the byte needs
    function void send_byte(logic rs, logic [7:0] b);
        logic [SUM_BITS-1:0] w;
        w       = SUM_BITS'(cmd_wait);
        sel_lvl = rs;
        strobe(b[7:4]);
        strobe(b[3:0]);
        if (!rs) begin
            if (b == INSTR_CLEAR) w = w + SUM_BITS'(clr_wait);
            if (b[7])             w = w + SUM_BITS'(addr_wait);
        end
        wait_left = clamp_wait(w);
    endfunction

    // expand one accepted input transfer into its expected results
    function void note_input(t_in it);
        logic acc;
        logic act;
        logic busy_now;
        acc      = 1'b1;
        busy_now = is_busy();
        group_q.delete();
        case (it.command)
            CMD_TICK: begin
                if (wait_left != '0) begin
                    wait_left = wait_left - 1'b1;
                    act       = (wait_left == '0);
                end else begin
                    act = 1'b1;
                end
                if (act) begin
                    case (phase)
                        INIT_RESET_1: begin
                            strobe(RESET_NIBBLE);
                            wait_left = clamp_wait(SUM_BITS'(INIT_LONG_WAIT));
                            phase     = INIT_RESET_2;
                        end
                        INIT_RESET_2: begin
                            strobe(RESET_NIBBLE);
                            wait_left = clamp_wait(SUM_BITS'(INIT_SHORT_WAIT));
                            phase     = INIT_RESET_3;
                        end
                        INIT_RESET_3: begin
                            strobe(RESET_NIBBLE);
                            wait_left = clamp_wait(SUM_BITS'(INIT_SHORT_WAIT));
                            phase     = INIT_BUS_4BIT;
                        end
                        // no wait after the bus-width nibble
                        INIT_BUS_4BIT: begin
                            sel_lvl = 1'b0;
                            strobe(BUS4_NIBBLE);
                            wait_left = '0;
                            phase     = INIT_FUNCTION;
                        end
                        INIT_FUNCTION: begin
                            send_byte(1'b0, function_byte);
                            phase = INIT_ENTRY;
                        end
                        INIT_ENTRY: begin
                            send_byte(1'b0, entry_byte);
                            phase = INIT_DISPLAY;
                        end
                        INIT_DISPLAY: begin
                            send_byte(1'b0, display_byte);
                            phase = INIT_CLEAR;
                        end
                        INIT_CLEAR: begin
                            send_byte(1'b0, INSTR_CLEAR);
                            phase = INIT_IDLE;
                        end
                        default: phase = INIT_IDLE;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (busy_now) acc = 1'b0;
                else          send_byte(it.register_select, it.byte_value);
            end
            CMD_START: begin
                if (busy_now) begin
                    acc = 1'b0;
                end else begin
                    sel_lvl   = 1'b0;
                    en_lvl    = 1'b0;
                    data_lvl  = 4'h0;
                    wait_left = clamp_wait(SUM_BITS'(power_wait));
                    phase     = INIT_RESET_1;
                end
            end
            default: acc = 1'b0;
        endcase
        if (group_q.size() == 0) push_pins();
        busy_now = is_busy();
        foreach (group_q[k]) begin
            group_q[k].accepted    = acc;
            group_q[k].busy_res    = busy_now;
            group_q[k].last_result = (k == group_q.size() - 1);
            pin_results_q.push_back(group_q[k]);
        end
    endfunction

    task report(string what);
        errors++;
        if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one output transfer with the oldest expectation
    task check_result(t_out got);
        t_out want;
        if (pin_results_q.size() == 0) begin
            report($sformatf("result %h with nothing expected", got));
            return;
        end
        want = pin_results_q.pop_front();
        if (got.accepted !== want.accepted)
            report($sformatf("accepted %b, want %b", got.accepted, want.accepted));
        if (got.busy_res !== want.busy_res)
            report($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
        if (got.enable_pin !== want.enable_pin)
            report($sformatf("enable_pin %b, want %b", got.enable_pin, want.enable_pin));
        if (got.select_pin !== want.select_pin)
            report($sformatf("select_pin %b, want %b", got.select_pin, want.select_pin));
        if (got.data_pins !== want.data_pins)
            report($sformatf("data_pins %h, want %h", got.data_pins, want.data_pins));
        if (got.last_result !== want.last_result)
            report($sformatf("last_result %b, want %b", got.last_result, want.last_result));
    endtask

endclass

module tb_char_lcd_nibble_interface_sequencer;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RX_HOLD_CYCLES = 200;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic                     o_stall;
    t_in                      i_data     = '0;
    logic                     o_valid;
    logic                     i_stall    = 1'b0;
    t_out                     o_data;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    lcd_pin_scoreboard pin_board;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;

    char_lcd_nibble_interface_sequencer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("char_lcd_nibble_interface_sequencer verification failed");
        $finish;
    end

    // receiver: random stall, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = RX_HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) pin_board.check_result(o_data);
    end

    function automatic t_in make_item(logic [1:0] cmd, logic rs, logic [7:0] b);
        t_in it;
        it.command         = cmd;
        it.register_select = rs;
        it.byte_value      = b;
        return it;
    endfunction

    // bias toward the clear and set-address instructions
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 25) return INSTR_CLEAR;
        if (r < 45) return 8'h80 | 8'($urandom_range(127));
        return 8'($urandom_range(255));
    endfunction

    // mostly ticks while busy; writes when free; starts only ever refused
    function automatic t_in random_item();
        int r;
        logic [1:0] cmd;
        r = $urandom_range(99);
        if (pin_board.is_busy()) begin
            if (r < 80)      cmd = CMD_TICK;
            else if (r < 90) cmd = CMD_WRITE;
            else if (r < 96) cmd = CMD_START;
            else             cmd = CMD_UNUSED;
        end else begin
            if (r < 60)      cmd = CMD_WRITE;
            else if (r < 94) cmd = CMD_TICK;
            else             cmd = CMD_UNUSED;
        end
        return make_item(cmd, 1'($urandom_range(1)), pick_byte());
    endfunction

    task automatic send_item(input t_in it);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        pin_board.note_input(it);
    endtask

    // tick until the sequencer is free, with a few refused items mixed in
    task automatic finish_waits();
        while (pin_board.is_busy()) begin
            if ($urandom_range(99) < 5) begin
                send_item(random_item());
            end else begin
                send_item(make_item(CMD_TICK, 1'($urandom_range(1)),
                                    8'($urandom_range(255))));
            end
        end
    endtask

    // sender holds off until every expected result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pin_board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        pin_board.write_reg(idx, v);
    endtask

    task automatic apply_settings(input logic [7:0] fs, input logic [7:0] em,
                                  input logic [7:0] dc, input logic rev,
                                  input logic [15:0] pw, input logic [7:0] cw,
                                  input logic [11:0] clw, input logic [7:0] aw);
        put_reg(REG_FUNCTION_SET, CFG_DATA_BITS'(fs));
        put_reg(REG_ENTRY_MODE, CFG_DATA_BITS'(em));
        put_reg(REG_DISPLAY_CONTROL, CFG_DATA_BITS'(dc));
        put_reg(REG_REVERSE_PINS, CFG_DATA_BITS'(rev));
        put_reg(REG_POWER_UP_WAIT, CFG_DATA_BITS'(pw));
        put_reg(REG_COMMAND_WAIT, CFG_DATA_BITS'(cw));
        put_reg(REG_CLEAR_WAIT, CFG_DATA_BITS'(clw));
        put_reg(REG_ADDRESS_WAIT, CFG_DATA_BITS'(aw));
        i_cfg_we <= 1'b0;
    endtask

    // random traffic with one long receiver hold-off, a full drain partway and one at the end
    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) hold_req = 1'b1;
            if (i == (2 * n) / 3) drain_results();
            send_item(random_item());
        end
        finish_waits();
        drain_results();
    endtask

    task automatic power_up_run();
        send_item(make_item(CMD_START, 1'($urandom_range(1)), 8'($urandom_range(255))));
        finish_waits();
    endtask

    initial begin
        pin_board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short waits, init bytes that hit the clear and address waits
        tx_idle_pct = 27;
        rx_idle_pct = 80;
        apply_settings(8'h00, 8'h01, 8'h80, 1'b1, 16'd3, 8'd2, 12'd3, 8'd2);
        send_item(make_item(CMD_TICK, 1'b0, 8'h00));
        send_item(make_item(CMD_UNUSED, 1'b1, 8'hFF));
        send_item(make_item(CMD_WRITE, 1'b1, 8'hFF));
        send_item(make_item(CMD_WRITE, 1'b0, 8'h00));
        send_item(make_item(CMD_START, 1'b0, 8'h00));
        finish_waits();
        send_item(make_item(CMD_WRITE, 1'b0, INSTR_CLEAR));
        finish_waits();
        send_item(make_item(CMD_WRITE, 1'b0, 8'h80));
        finish_waits();
        send_item(make_item(CMD_WRITE, 1'b1, 8'h81));
        finish_waits();
        send_item(make_item(CMD_WRITE, 1'b1, INSTR_CLEAR));
        finish_waits();
        send_item(make_item(CMD_WRITE, 1'b0, 8'hC0));
        finish_waits();
        send_item(make_item(CMD_WRITE, 1'b0, 8'h5A));
        finish_waits();
        power_up_run();
        random_phase(90);

        // no configurable waits, straight pin order
        tx_idle_pct = 80;
        rx_idle_pct = 27;
        apply_settings(8'hFF, 8'h00, 8'h0C, 1'b0, 16'd0, 8'd0, 12'd0, 8'd0);
        power_up_run();
        random_phase(90);

        // longest byte waits, short power-up wait
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_settings(8'($urandom_range(255)), 8'hFF, 8'hFF, 1'b1,
                       16'd9, 8'hFF, 12'hFFF, 8'hFF);
        power_up_run();
        random_phase(70);

        // random short settings
        apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'($urandom_range(1)),
                       16'($urandom_range(7)), 8'($urandom_range(3)),
                       12'($urandom_range(5)), 8'($urandom_range(5)));
        power_up_run();
        random_phase(100);

        repeat (16) @(posedge i_clk);
        if (pin_board.errors == 0 && pin_board.pending() == 0) begin
            $display("char_lcd_nibble_interface_sequencer verification clean");
        end else begin
            $display("char_lcd_nibble_interface_sequencer verification failed");
        end
        $finish;
    end

endmodule
